// ===== rtl/core/ascii_log_frame_crc_checker_macros.svh =====
// Assertion macros for the line checker, clocked on i_clk, held off in reset.
`ifndef ASCII_LOG_FRAME_CRC_CHECKER_MACROS_SVH
`define ASCII_LOG_FRAME_CRC_CHECKER_MACROS_SVH

`define ALFCC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// antecedent one cycle, consequent the next
`define ALFCC_ASSERT_NEXT(label, ante, cons, msg) \
    `ALFCC_ASSERT(label, ante |=> cons, msg)

`endif

// ===== rtl/core/alfcc_pkg.sv =====
`timescale 1ns / 1ps

package alfcc_pkg;

    localparam int NAME_COUNT = 7;
    localparam int MAX_NAME   = 15;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_STAR  = 8'h2A;

    localparam logic [3:0] HEX_DIGITS     = 4'd8;
    localparam logic [3:0] HEADER_COMMAS  = 4'd9;
    localparam logic [3:0] COUNT_SAT      = 4'hF;

    typedef logic [2:0] t_status;
    localparam t_status ST_NOT_RECOG  = 3'd0;
    localparam t_status ST_OK         = 3'd1;
    localparam t_status ST_BAD_FRAME  = 3'd2;
    localparam t_status ST_CRC_MISS   = 3'd3;
    localparam t_status ST_NO_SEP     = 3'd4;
    localparam t_status ST_HDR_COUNT  = 3'd5;

    localparam logic [8*MAX_NAME-1:0] NAME_STR [NAME_COUNT] = '{
        "GPSEPHEMA", "GLOEPHEMERISA", "GALEPHEMERISA", "BD2EPHEMA",
        "QZSSEPHEMERISA", "IONUTCA", "BD2IONUTCA"
    };
    localparam logic [3:0] NAME_LEN [NAME_COUNT] = '{
        4'd9, 4'd13, 4'd13, 4'd9, 4'd14, 4'd7, 4'd10
    };

    typedef struct packed {
        logic        pos_zero;
        logic        starts_hash;
        logic        name_done;
        logic [3:0]  name_len;
        logic [6:0]  name_mask;
        logic        recognized;
        logic [2:0]  kind;
        logic [31:0] crc;
        logic [31:0] crc_star;
        logic        star_seen;
        logic [31:0] hex_acc;
        logic [3:0]  hex_cnt;
        logic        hex_ok;
        logic        sep_seen;
        logic        sep_before_star;
        logic [3:0]  comma_cnt;
    } t_line;

    localparam t_line LINE_CLEAR = '{
        pos_zero: 1'b1, starts_hash: 1'b0, name_done: 1'b0, name_len: 4'd0,
        name_mask: 7'h7F, recognized: 1'b0, kind: 3'd0, crc: 32'd0,
        crc_star: 32'd0, star_seen: 1'b0, hex_acc: 32'd0, hex_cnt: 4'd0,
        hex_ok: 1'b1, sep_seen: 1'b0, sep_before_star: 1'b0, comma_cnt: 4'd0
    };

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= "0" && c <= "9") begin
            r = {1'b1, 4'(c - "0")};
        end else if (c >= "a" && c <= "f") begin
            r = {1'b1, 4'(c - "a" + 8'd10)};
        end else if (c >= "A" && c <= "F") begin
            r = {1'b1, 4'(c - "A" + 8'd10)};
        end
        return r;
    endfunction

    function automatic logic [7:0] name_char(input int k, input logic [3:0] pos);
        logic [7:0] ch;
        ch = NAME_STR[k][8*(int'(NAME_LEN[k]) - 1 - int'(pos)) +: 8];
        return ch;
    endfunction

    function automatic t_line take_byte(input t_line s_in, input logic [7:0] c);
        t_line      s;
        logic [4:0] hv;
        s  = s_in;
        hv = hex_value(c);
        if (s.pos_zero) begin
            s.pos_zero    = 1'b0;
            s.starts_hash = (c == CH_HASH);
        end else if (s.starts_hash) begin
            if (!s.name_done) begin
                if (c == CH_COMMA) begin
                    s.name_done = 1'b1;
                    for (int k = 0; k < NAME_COUNT; k++) begin
                        if (s.name_len != 4'd0 && s_in.name_mask[k] &&
                            NAME_LEN[k] == s.name_len) begin
                            s.recognized = 1'b1;
                            s.kind       = 3'(k);
                        end
                    end
                end else begin
                    for (int k = 0; k < NAME_COUNT; k++) begin
                        if (s_in.name_len >= NAME_LEN[k]) begin
                            s.name_mask[k] = 1'b0;
                        end else if (name_char(k, s_in.name_len) != c) begin
                            s.name_mask[k] = 1'b0;
                        end
                    end
                    if (s.name_len != COUNT_SAT) s.name_len = s.name_len + 4'd1;
                end
            end
            if (c == CH_COMMA && !s.sep_seen && s.comma_cnt != COUNT_SAT) begin
                s.comma_cnt = s.comma_cnt + 4'd1;
            end
            if (c == CH_SEMI) s.sep_seen = 1'b1;
            if (c == CH_STAR) begin
                s.crc_star        = s.crc;
                s.star_seen       = 1'b1;
                s.sep_before_star = s.sep_seen;
                s.hex_acc         = 32'd0;
                s.hex_cnt         = 4'd0;
                s.hex_ok          = 1'b1;
            end else begin
                if (s.hex_cnt != COUNT_SAT) s.hex_cnt = s.hex_cnt + 4'd1;
                if (!hv[4]) s.hex_ok = 1'b0;
                else s.hex_acc = {s.hex_acc[27:0], hv[3:0]};
            end
            s.crc = crc_byte(s.crc, c);
        end
        return s;
    endfunction

endpackage

// ===== rtl/core/ascii_log_frame_crc_checker.sv =====
`timescale 1ns / 1ps
// Line checker for framed ASCII log records with a CRC-32 trailer.
// Input channel: one text byte per word on i_text_byte, i_in_valid/o_in_ready.
// Output channel: one verdict word per newline on o_status, o_log_kind and
// o_computed_crc, o_out_valid/i_out_ready. Other bytes produce no word.
// Every byte but a newline is folded into the line state in the cycle it is
// taken, so the block takes one byte per cycle while o_in_ready is high; a CR
// held back for the newline test joins the next byte, or is dropped at a LF.
// A verdict is shown the cycle after its newline is taken if the output is free.
// Throughput: one byte per cycle, sustained, with the receiver ready.
// The output has a main register and a skid register: while the receiver
// stalls, bytes keep flowing until a second verdict fills the skid stage,
// then o_in_ready drops until the receiver takes a word.
// Reset (synchronous, active low) clears the line state and empties both
// output registers; no word is pending afterwards.
module ascii_log_frame_crc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_text_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [2:0]  o_log_kind,
    output logic [31:0] o_computed_crc
);

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  kind;
        logic [31:0] crc;
    } t_verdict;

    alfcc_pkg::t_line r_line, n_line, w_after_cr;
    logic             r_cr_pending, n_cr_pending;
    logic             r_out_v, r_sk_v;
    t_verdict         r_out, r_sk, w_verdict;
    logic             w_take, w_newline, w_push, w_pop;

    assign o_in_ready = !r_sk_v;
    assign w_take     = i_in_valid && o_in_ready;
    assign w_newline  = (i_text_byte == alfcc_pkg::CH_LF);
    assign w_push     = w_take && w_newline;
    assign w_pop      = r_out_v && i_out_ready;

    always_comb begin
        w_after_cr = r_cr_pending ? alfcc_pkg::take_byte(r_line, alfcc_pkg::CH_CR)
                                  : r_line;
        n_line       = r_line;
        n_cr_pending = r_cr_pending;
        if (w_take) begin
            if (w_newline) begin
                n_line       = alfcc_pkg::LINE_CLEAR;
                n_cr_pending = 1'b0;
            end else if (i_text_byte == alfcc_pkg::CH_CR) begin
                n_line       = w_after_cr;
                n_cr_pending = 1'b1;
            end else begin
                n_line       = alfcc_pkg::take_byte(w_after_cr, i_text_byte);
                n_cr_pending = 1'b0;
            end
        end
    end

    always_comb begin
        w_verdict = '0;
        if (r_line.starts_hash && r_line.recognized) begin
            w_verdict.kind = r_line.kind;
            if (!r_line.star_seen || r_line.hex_cnt != alfcc_pkg::HEX_DIGITS) begin
                w_verdict.status = alfcc_pkg::ST_BAD_FRAME;
            end else if (!r_line.hex_ok || r_line.hex_acc != r_line.crc_star) begin
                w_verdict.status = alfcc_pkg::ST_CRC_MISS;
            end else if (!r_line.sep_before_star) begin
                w_verdict.status = alfcc_pkg::ST_NO_SEP;
            end else if (r_line.comma_cnt != alfcc_pkg::HEADER_COMMAS) begin
                w_verdict.status = alfcc_pkg::ST_HDR_COUNT;
            end else begin
                w_verdict.status = alfcc_pkg::ST_OK;
            end
            if (r_line.star_seen) w_verdict.crc = r_line.crc_star;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line       <= alfcc_pkg::LINE_CLEAR;
            r_cr_pending <= 1'b0;
            r_out_v      <= 1'b0;
            r_sk_v       <= 1'b0;
        end else begin
            r_line       <= n_line;
            r_cr_pending <= n_cr_pending;
            if (r_sk_v) begin
                if (w_pop) begin
                    r_out  <= r_sk;
                    r_sk_v <= 1'b0;
                end
            end else if (!r_out_v || w_pop) begin
                r_out_v <= w_push;
                if (w_push) r_out <= w_verdict;
            end else if (w_push) begin
                r_sk   <= w_verdict;
                r_sk_v <= 1'b1;
            end
        end
    end

    assign o_out_valid    = r_out_v;
    assign o_status       = r_out.status;
    assign o_log_kind     = r_out.kind;
    assign o_computed_crc = r_out.crc;

endmodule

// ===== rtl/core/alfcc_checker.sv =====
`timescale 1ns / 1ps
`include "ascii_log_frame_crc_checker_macros.svh"

module alfcc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [7:0]  i_text_byte,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_status,
    input logic [2:0]  o_log_kind,
    input logic [31:0] o_computed_crc
);

    `ALFCC_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "verdict dropped while stalled")
    `ALFCC_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_status) && $stable(o_log_kind) && $stable(o_computed_crc), "verdict changed while stalled")
    `ALFCC_ASSERT(a_unrecog_zero, o_out_valid && o_status == alfcc_pkg::ST_NOT_RECOG |-> o_log_kind == 3'd0 && o_computed_crc == 32'd0, "unrecognised line carries kind or crc")
    `ALFCC_ASSERT(a_codes_range, o_out_valid |-> o_status <= alfcc_pkg::ST_HDR_COUNT && o_log_kind <= 3'd6, "status or kind out of range")
    `ALFCC_ASSERT_NEXT(a_no_spurious, i_in_valid && o_in_ready && i_text_byte != alfcc_pkg::CH_LF && !o_out_valid, !o_out_valid, "verdict without newline")

endmodule

bind ascii_log_frame_crc_checker alfcc_checker u_alfcc_checker (.*);

// ===== test/ascii_log_frame_crc_checker_test.sv =====
`timescale 1ns / 1ps

module ascii_log_frame_crc_checker_test;

    localparam int STALL_PCT      = 31;
    localparam int CALM_LO        = 300;
    localparam int CALM_HI        = 600;
    localparam int HOLD_AT        = 700;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_BYTES   = 1250;
    localparam int DRAIN_CYCLES   = 8;

    // name selection beyond the seven log names
    localparam int NM_EMPTY   = 7;
    localparam int NM_GARBAGE = 8;
    localparam int NM_TRUNC   = 9;

    localparam int SEP_NONE   = 0;
    localparam int SEP_BEFORE = 1;

    localparam int TR_UPPER  = 0;
    localparam int TR_LOWER  = 1;
    localparam int TR_WRONG  = 2;
    localparam int TR_SHORT  = 3;
    localparam int TR_LONG   = 4;
    localparam int TR_NONE   = 5;
    localparam int TR_PREFIX = 6;
    localparam int TR_SIGN   = 7;

    localparam int EOL_LF     = 0;
    localparam int EOL_CRLF   = 1;
    localparam int EOL_CRCRLF = 2;

    typedef struct packed {
        alfcc_pkg::t_status status;
        logic [2:0]         kind;
        logic [31:0]        crc;
    } t_verdict;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_text_byte = 8'd0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_status;
    logic [2:0]  o_log_kind;
    logic [31:0] o_computed_crc;

    ascii_log_frame_crc_checker u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_text_byte    (i_text_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_log_kind     (o_log_kind),
        .o_computed_crc (o_computed_crc)
    );

    logic [7:0] text_q[$];
    t_verdict   verdict_q[$];

    // line state of the predictor
    bit          cr_held;
    bit          at_line_start;
    bit          hash_line;
    bit          name_closed;
    logic [3:0]  name_cnt;
    logic [6:0]  name_hits;
    bit          known;
    logic [2:0]  kind_sel;
    logic [31:0] crc_run;
    logic [31:0] crc_mark;
    bit          star_hit;
    logic [31:0] hex_word;
    logic [3:0]  hex_cnt;
    bit          hex_good;
    bit          semi_hit;
    bit          semi_before_mark;
    logic [3:0]  comma_cnt;

    int bytes_taken   = 0;
    int lines_made    = 0;
    int verdicts_seen = 0;
    int error_count   = 0;
    int status_seen[6];
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    int idle_cycles   = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic put_byte(input logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endtask

    function automatic string name_of(input int k);
        case (k)
            0: return "GPSEPHEMA";
            1: return "GLOEPHEMERISA";
            2: return "GALEPHEMERISA";
            3: return "BD2EPHEMA";
            4: return "QZSSEPHEMERISA";
            5: return "IONUTCA";
            default: return "BD2IONUTCA";
        endcase
    endfunction

    function automatic logic [31:0] crc_step(input logic [31:0] r, input logic [7:0] b);
        logic [31:0] c;
        c = r ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ alfcc_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] v);
        v = 4'd0;
        if (c >= "0" && c <= "9") begin
            v = 4'(c - 8'h30);
            return 1'b1;
        end
        if (c >= "a" && c <= "f") begin
            v = 4'(c - 8'h57);
            return 1'b1;
        end
        if (c >= "A" && c <= "F") begin
            v = 4'(c - 8'h37);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic start_line();
        at_line_start    = 1'b1;
        hash_line        = 1'b0;
        name_closed      = 1'b0;
        name_cnt         = 4'd0;
        name_hits        = 7'h7F;
        known            = 1'b0;
        kind_sel         = 3'd0;
        crc_run          = 32'd0;
        crc_mark         = 32'd0;
        star_hit         = 1'b0;
        hex_word         = 32'd0;
        hex_cnt          = 4'd0;
        hex_good         = 1'b1;
        semi_hit         = 1'b0;
        semi_before_mark = 1'b0;
        comma_cnt        = 4'd0;
    endtask

    task automatic absorb_char(input logic [7:0] c);
        string      nm;
        logic [3:0] nib;
        if (at_line_start) begin
            at_line_start = 1'b0;
            hash_line     = (c == alfcc_pkg::CH_HASH);
        end else if (hash_line) begin
            if (!name_closed) begin
                if (c == alfcc_pkg::CH_COMMA) begin
                    name_closed = 1'b1;
                    for (int k = 0; k < alfcc_pkg::NAME_COUNT; k++) begin
                        nm = name_of(k);
                        if (name_cnt != 4'd0 && name_hits[k] && nm.len() == name_cnt) begin
                            known    = 1'b1;
                            kind_sel = 3'(k);
                        end
                    end
                end else begin
                    for (int k = 0; k < alfcc_pkg::NAME_COUNT; k++) begin
                        nm = name_of(k);
                        if (name_cnt >= nm.len()) begin
                            name_hits[k] = 1'b0;
                        end else if (nm[name_cnt] != c) begin
                            name_hits[k] = 1'b0;
                        end
                    end
                    if (name_cnt != alfcc_pkg::COUNT_SAT) name_cnt = name_cnt + 4'd1;
                end
            end
            if (c == alfcc_pkg::CH_COMMA && !semi_hit &&
                    comma_cnt != alfcc_pkg::COUNT_SAT) begin
                comma_cnt = comma_cnt + 4'd1;
            end
            if (c == alfcc_pkg::CH_SEMI) semi_hit = 1'b1;
            if (c == alfcc_pkg::CH_STAR) begin
                crc_mark         = crc_run;
                star_hit         = 1'b1;
                semi_before_mark = semi_hit;
                hex_word         = 32'd0;
                hex_cnt          = 4'd0;
                hex_good         = 1'b1;
            end else begin
                if (hex_cnt != alfcc_pkg::COUNT_SAT) hex_cnt = hex_cnt + 4'd1;
                if (hex_digit(c, nib)) hex_word = {hex_word[27:0], nib};
                else hex_good = 1'b0;
            end
            crc_run = crc_step(crc_run, c);
        end
    endtask

    task automatic predict_byte(input logic [7:0] c);
        t_verdict v;
        if (c != alfcc_pkg::CH_LF) begin
            if (cr_held) begin
                cr_held = 1'b0;
                absorb_char(alfcc_pkg::CH_CR);
            end
            if (c == alfcc_pkg::CH_CR) cr_held = 1'b1;
            else absorb_char(c);
        end else begin
            cr_held  = 1'b0;
            v.status = alfcc_pkg::ST_NOT_RECOG;
            v.kind   = 3'd0;
            v.crc    = 32'd0;
            if (hash_line && known) begin
                v.kind = kind_sel;
                if (!star_hit || hex_cnt != alfcc_pkg::HEX_DIGITS) begin
                    v.status = alfcc_pkg::ST_BAD_FRAME;
                end else if (!hex_good || hex_word != crc_mark) begin
                    v.status = alfcc_pkg::ST_CRC_MISS;
                end else if (!semi_before_mark) begin
                    v.status = alfcc_pkg::ST_NO_SEP;
                end else if (comma_cnt != alfcc_pkg::HEADER_COMMAS) begin
                    v.status = alfcc_pkg::ST_HDR_COUNT;
                end else begin
                    v.status = alfcc_pkg::ST_OK;
                end
                if (star_hit) v.crc = crc_mark;
            end
            verdict_q.insert(verdict_q.size(), v);
            start_line();
        end
    endtask

    // stimulus construction
    function automatic logic [7:0] field_char();
        logic [7:0] b;
        if ($urandom_range(19) == 0) return alfcc_pkg::CH_CR;
        do begin
            b = 8'($urandom_range(126, 32));
        end while (b == alfcc_pkg::CH_COMMA || b == alfcc_pkg::CH_SEMI ||
                   b == alfcc_pkg::CH_STAR);
        return b;
    endfunction

    task automatic push_hex(input logic [31:0] v, input int digits, input bit lower);
        logic [3:0] nib;
        for (int i = digits - 1; i >= 0; i--) begin
            nib = v[4*i +: 4];
            if (nib < 4'd10) put_byte(8'h30 + 8'(nib));
            else put_byte((lower ? 8'h57 : 8'h37) + 8'(nib));
        end
    endtask

    task automatic put_record(input int name_sel, input int commas, input int sep_mode,
                              input int trailer, input int eol);
        logic [7:0]  body[$];
        logic [31:0] sig;
        string       nm;
        int          n;
        if (name_sel < alfcc_pkg::NAME_COUNT || name_sel == NM_TRUNC) begin
            nm = name_of(name_sel < alfcc_pkg::NAME_COUNT ? name_sel
                                                          : $urandom_range(alfcc_pkg::NAME_COUNT - 1));
            n  = (name_sel == NM_TRUNC) ? nm.len() - 1 : nm.len();
            for (int i = 0; i < n; i++) body.insert(body.size(), nm[i]);
        end else if (name_sel == NM_GARBAGE) begin
            repeat ($urandom_range(17, 1)) begin
                if ($urandom_range(3) == 0) begin
                    body.insert(body.size(), 8'h30 + 8'($urandom_range(9)));
                end else begin
                    body.insert(body.size(), 8'h41 + 8'($urandom_range(25)));
                end
            end
        end
        repeat (commas) begin
            body.insert(body.size(), alfcc_pkg::CH_COMMA);
            repeat ($urandom_range(2)) body.insert(body.size(), field_char());
        end
        if (sep_mode == SEP_BEFORE) body.insert(body.size(), alfcc_pkg::CH_SEMI);
        repeat ($urandom_range(4)) body.insert(body.size(), field_char());
        // an early star, overridden by the real trailer when there is one
        if ($urandom_range(3) == 0) begin
            body.insert(body.size(), alfcc_pkg::CH_STAR);
            body.insert(body.size(), field_char());
        end
        sig = 32'd0;
        foreach (body[i]) sig = crc_step(sig, body[i]);
        put_byte(alfcc_pkg::CH_HASH);
        foreach (body[i]) put_byte(body[i]);
        if (trailer != TR_NONE) put_byte(alfcc_pkg::CH_STAR);
        case (trailer)
            TR_UPPER: push_hex(sig, 8, 1'b0);
            TR_LOWER: push_hex(sig, 8, 1'b1);
            TR_WRONG: push_hex(sig ^ (32'd1 << $urandom_range(31)), 8, 1'($urandom_range(1)));
            TR_SHORT: push_hex(sig, 7, 1'b0);
            TR_LONG: begin
                repeat ($urandom_range(12, 1)) put_byte("0");
                push_hex(sig, 8, 1'b0);
            end
            TR_PREFIX: begin
                put_byte("0");
                put_byte("x");
                push_hex(sig, 6, 1'b0);
            end
            TR_SIGN: begin
                case ($urandom_range(2))
                    0: put_byte("+");
                    1: put_byte("-");
                    default: put_byte(" ");
                endcase
                push_hex(sig, 7, 1'b0);
            end
            default: ;
        endcase
        if (eol != EOL_LF) put_byte(alfcc_pkg::CH_CR);
        if (eol == EOL_CRCRLF) put_byte(alfcc_pkg::CH_CR);
        put_byte(alfcc_pkg::CH_LF);
        lines_made++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
        put_byte(alfcc_pkg::CH_LF);
        lines_made++;
    endtask

    task automatic put_noise(input bit hashed, input bit any_byte);
        logic [7:0] b;
        if (hashed) put_byte(alfcc_pkg::CH_HASH);
        repeat ($urandom_range(20)) begin
            b = any_byte ? 8'($urandom_range(255)) : field_char();
            if (b == alfcc_pkg::CH_LF) b = 8'h0B;
            put_byte(b);
        end
        put_byte(alfcc_pkg::CH_LF);
        lines_made++;
    endtask

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 10) $display("%s", msg);
    endtask

    task automatic check_verdict();
        t_verdict want;
        if (o_status <= alfcc_pkg::ST_HDR_COUNT) status_seen[o_status]++;
        if (verdict_q.size() == 0) begin
            flag_error($sformatf("unexpected verdict: status %0d kind %0d crc %08h",
                                 o_status, o_log_kind, o_computed_crc));
        end else begin
            want = verdict_q.pop_front();
            verdicts_seen++;
            if (o_status !== want.status || o_log_kind !== want.kind ||
                    o_computed_crc !== want.crc) begin
                flag_error($sformatf(
                    "verdict %0d: exp status %0d kind %0d crc %08h, got status %0d kind %0d crc %08h",
                    verdicts_seen, want.status, want.kind, want.crc,
                    o_status, o_log_kind, o_computed_crc));
            end
        end
    endtask

    function automatic bit calm_now();
        return bytes_taken >= CALM_LO && bytes_taken < CALM_HI;
    endfunction

    // byte driver, predictor fed from accepted words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_byte(i_text_byte);
                bytes_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (text_q.size() != 0 &&
                        (calm_now() || hold_left != 0 || $urandom_range(99) >= STALL_PCT)) begin
                    i_in_valid  <= 1'b1;
                    i_text_byte <= text_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // verdict monitor and receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_left   <= 0;
        end else begin
            if (o_out_valid && i_out_ready) check_verdict();
            if (hold_left != 0) begin
                hold_left   <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else if (!hold_done && bytes_taken >= HOLD_AT) begin
                hold_left   <= HOLD_CYCLES;
                hold_done   <= 1'b1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= calm_now() || ($urandom_range(99) >= STALL_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no word moved for %0d cycles, %0d verdicts outstanding",
                     idle_cycles, verdict_q.size());
            $display("ascii_log_frame_crc_checker regression: fail");
            $finish;
        end
    end

    initial begin
        int target;
        int pick;
        cr_held = 1'b0;
        start_line();

        // directed: every log name, every verdict, trailer forms, CR handling
        for (int k = 0; k < alfcc_pkg::NAME_COUNT; k++) begin
            put_record(k, 9, SEP_BEFORE, (k % 2) ? TR_LOWER : TR_UPPER, k % 3);
        end
        put_record(0, 9, SEP_BEFORE, TR_NONE, EOL_LF);
        put_record(1, 9, SEP_BEFORE, TR_WRONG, EOL_CRLF);
        put_record(2, 9, SEP_NONE, TR_UPPER, EOL_LF);
        put_record(3, 8, SEP_BEFORE, TR_UPPER, EOL_LF);
        put_record(4, 17, SEP_BEFORE, TR_LONG, EOL_CRCRLF);
        put_record(5, 9, SEP_BEFORE, TR_SHORT, EOL_LF);
        put_record(6, 9, SEP_BEFORE, TR_PREFIX, EOL_LF);
        put_record(0, 9, SEP_BEFORE, TR_SIGN, EOL_LF);
        put_record(NM_EMPTY, 9, SEP_BEFORE, TR_UPPER, EOL_LF);
        put_record(NM_GARBAGE, 9, SEP_BEFORE, TR_UPPER, EOL_LF);
        put_record(NM_TRUNC, 9, SEP_BEFORE, TR_UPPER, EOL_LF);
        put_text("#GPSEPHEMA");
        put_text("");
        put_text("GPSEPHEMA,");
        // extreme byte values and a CR that is not line end
        put_byte(alfcc_pkg::CH_HASH);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(alfcc_pkg::CH_CR);
        put_byte("A");
        put_byte(alfcc_pkg::CH_LF);
        lines_made++;

        target = RANDOM_BYTES;
        while (text_q.size() < target) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                put_record($urandom_range(alfcc_pkg::NAME_COUNT - 1), 9, SEP_BEFORE,
                           $urandom_range(1) ? TR_UPPER : TR_LOWER, $urandom_range(2));
            end else if (pick < 85) begin
                put_record($urandom_range(NM_TRUNC),
                           $urandom_range(1) ? $urandom_range(11, 7) : $urandom_range(17),
                           $urandom_range(1), $urandom_range(TR_SIGN), $urandom_range(2));
            end else begin
                put_noise(1'($urandom_range(1)), 1'($urandom_range(1)));
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (text_q.size() != 0 || i_in_valid) @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d bytes over %0d lines sent, %0d verdicts checked, %0d mismatches",
                 bytes_taken, lines_made, verdicts_seen, error_count);
        $display("by status: unknown %0d ok %0d framing %0d crc %0d no-sep %0d commas %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5]);
        if (error_count == 0) begin
            $display("ascii_log_frame_crc_checker regression: pass");
        end else begin
            $display("ascii_log_frame_crc_checker regression: fail");
        end
        $finish;
    end

endmodule
